// ===== design/hbbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbbc_pkg: shared types and constants of the block buffer cache
// Request and status codes, field widths, and the structs that run
// between the control logic and the row of slot cells.
// ----------------------------------------------------------------------------
package hbbc_pkg;

	localparam int unsigned SLOT_W = 5;
	localparam int unsigned DEV_W = 16;
	localparam int unsigned BLK_W = 32;
	localparam int unsigned CNT_W = 8;

	localparam logic [CNT_W-1:0] COUNT_LIMIT = 8'hFF;

	localparam int unsigned NUM_SLOTS_DEF = 30;

	typedef enum logic [1:0] {
		REQ_GET = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_PIN = 2'd2,
		REQ_UNPIN = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_ZERO = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	// carried from cell to cell along the row, lowest slot first
	typedef struct packed {
		logic hit;
		logic hit_max;
		logic hit_inval;
		logic [SLOT_W-1:0] hit_idx;
		logic free;
		logic [SLOT_W-1:0] free_idx;
		logic sel_zero;
		logic sel_max;
	} chain_t;

	// broadcast from the control logic to every cell
	typedef struct packed {
		logic cmp;
		logic go;
		logic hit_inc;
		logic alloc;
		logic pin;
		logic dec;
		logic release_op;
		logic [DEV_W-1:0] dev;
		logic [BLK_W-1:0] blk;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/hbbc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbbc_cell: one buffer slot
// Holds the tag, valid flag, reference count and bucket membership of one
// slot, compares the tag against the request and takes its place in the
// priority chain that picks the first hit and the first free slot.
// ----------------------------------------------------------------------------
module hbbc_cell #(
	parameter int unsigned IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hbbc_pkg::cmd_t cmd,
	input wire hbbc_pkg::chain_t chain_in,
	output hbbc_pkg::chain_t chain_out
);
	import hbbc_pkg::*;

	localparam logic [SLOT_W-1:0] IDX_V = SLOT_W'(IDX);

	logic [DEV_W-1:0] dev_q;
	logic [BLK_W-1:0] blk_q;
	logic valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic member_q;
	logic match_s1;

	logic is_sel;
	logic zero;
	logic at_max;
	logic first_hit;
	logic first_free;

	always_comb begin
		is_sel = (cmd.slot == IDX_V);
		zero = (cnt_q == '0);
		at_max = (cnt_q == COUNT_LIMIT);
		first_hit = match_s1 && !chain_in.hit;
		first_free = zero && !chain_in.free;

		chain_out = chain_in;
		if (first_hit) begin
			chain_out.hit = 1'b1;
			chain_out.hit_max = at_max;
			chain_out.hit_inval = !valid_q;
			chain_out.hit_idx = IDX_V;
		end
		if (first_free) begin
			chain_out.free = 1'b1;
			chain_out.free_idx = IDX_V;
		end
		if (is_sel) begin
			chain_out.sel_zero = zero;
			chain_out.sel_max = at_max;
		end
	end

	// member_q stands for this slot's bit in the bucket of its own tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
			member_q <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (cmd.cmp) begin
				match_s1 <= member_q && (dev_q == cmd.dev) && (blk_q == cmd.blk);
			end
			if (cmd.go) begin
				if (cmd.hit_inc && first_hit) begin
					cnt_q <= cnt_q + CNT_W'(1);
					valid_q <= 1'b1;
				end else if (cmd.alloc && first_free) begin
					cnt_q <= CNT_W'(1);
					valid_q <= 1'b1;
					member_q <= 1'b1;
				end else if (cmd.pin && is_sel) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (cmd.dec && is_sel) begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cmd.release_op && cnt_q == CNT_W'(1)) begin
						member_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && cmd.alloc && first_free) begin
			dev_q <= cmd.dev;
			blk_q <= cmd.blk;
		end
	end

endmodule
`default_nettype wire

// ===== design/hashed_block_buffer_cache_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_core: slot manager of a disk block buffer cache
// Serves get, release, pin and unpin requests over a row of slot cells
// with reference counts and per-bucket membership.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  request   in_valid / in_stall      req_type, device_id, block_number, slot_index
//  result    out_valid / out_stall    slot_out, was_hit, needs_read, status
//
//  A request passes capture, tag compare in every cell, then the
//  priority chain through the cell row picks the slot and the state updates.
//  One request is in flight at a time; the next is taken once the previous
//  result has moved into the output register.
//  Reset clears all counts, valid flags and bucket membership.
//  A stalled result holds the last stage until the output register frees.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_core #(
	parameter int unsigned NUM_SLOTS = hbbc_pkg::NUM_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] req_type,
	input wire logic [hbbc_pkg::DEV_W-1:0] device_id,
	input wire logic [hbbc_pkg::BLK_W-1:0] block_number,
	input wire logic [hbbc_pkg::SLOT_W-1:0] slot_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic [hbbc_pkg::SLOT_W-1:0] slot_out,
	output logic was_hit,
	output logic needs_read,
	output logic [1:0] status
);
	import hbbc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP = 3'b010,
		S_SEL = 3'b100
	} state_t;

	state_t state_q;

	req_t rq_type_q;
	logic [DEV_W-1:0] rq_dev_q;
	logic [BLK_W-1:0] rq_blk_q;
	logic [SLOT_W-1:0] rq_slot_q;

	logic res_valid_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic res_hit_q;
	logic res_read_q;
	status_t res_status_q;

	chain_t link [NUM_SLOTS+1];
	chain_t tail;
	cmd_t cmd;

	logic accept;
	logic sel_go;
	logic slot_ok;
	logic sel_zero;
	logic sel_max;
	logic [SLOT_W-1:0] nx_slot;
	logic nx_hit;
	logic nx_read;
	status_t nx_status;
	logic do_hit_inc;
	logic do_alloc;
	logic do_pin;
	logic do_dec;

	assign link[0] = '0;
	assign tail = link[NUM_SLOTS];

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		hbbc_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.chain_in(link[i]),
			.chain_out(link[i+1])
		);
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign sel_go = (state_q == S_SEL) && (!res_valid_q || !out_stall);

	// a slot index past the row reports both count zero and count at the limit
	assign slot_ok = ({1'b0, rq_slot_q} < (SLOT_W+1)'(NUM_SLOTS));
	assign sel_zero = slot_ok ? tail.sel_zero : 1'b1;
	assign sel_max = slot_ok ? tail.sel_max : 1'b1;

	always_comb begin
		nx_slot = rq_slot_q;
		nx_hit = 1'b0;
		nx_read = 1'b0;
		nx_status = ST_OK;
		do_hit_inc = 1'b0;
		do_alloc = 1'b0;
		do_pin = 1'b0;
		do_dec = 1'b0;
		unique case (rq_type_q) inside
			REQ_GET: begin
				if (tail.hit) begin
					nx_slot = tail.hit_idx;
					nx_hit = 1'b1;
					if (tail.hit_max) begin
						nx_status = ST_LIMIT;
					end else begin
						nx_read = tail.hit_inval;
						do_hit_inc = 1'b1;
					end
				end else if (tail.free) begin
					nx_slot = tail.free_idx;
					nx_read = 1'b1;
					do_alloc = 1'b1;
				end else begin
					nx_slot = '0;
					nx_status = ST_NO_FREE;
				end
			end
			REQ_PIN: begin
				if (sel_max) begin
					nx_status = ST_LIMIT;
				end else begin
					do_pin = 1'b1;
				end
			end
			REQ_RELEASE, REQ_UNPIN: begin
				if (sel_zero) begin
					nx_status = ST_ZERO;
				end else begin
					do_dec = 1'b1;
				end
			end
			default: begin
				nx_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		cmd.cmp = (state_q == S_CMP);
		cmd.go = sel_go;
		cmd.hit_inc = do_hit_inc;
		cmd.alloc = do_alloc;
		cmd.pin = do_pin;
		cmd.dec = do_dec;
		cmd.release_op = (rq_type_q == REQ_RELEASE);
		cmd.dev = rq_dev_q;
		cmd.blk = rq_blk_q;
		cmd.slot = rq_slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (sel_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (sel_go) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rq_type_q <= req_t'(req_type);
			rq_dev_q <= device_id;
			rq_blk_q <= block_number;
			rq_slot_q <= slot_index;
		end
		if (sel_go) begin
			res_slot_q <= nx_slot;
			res_hit_q <= nx_hit;
			res_read_q <= nx_read;
			res_status_q <= nx_status;
		end
	end

	assign out_valid = res_valid_q;
	assign slot_out = res_slot_q;
	assign was_hit = res_hit_q;
	assign needs_read = res_read_q;
	assign status = res_status_q;

endmodule
`default_nettype wire
